// ===== hw/rtl/pmsm_tc_pkg.sv =====
// Shared types and constants for the PMSM torque/current conversion block.
// Holds the command codes, register indexes and the pipeline stage records.
// No dependencies.
`timescale 1ns / 1ps

package pmsm_tc_pkg;

    typedef enum logic [1:0] {
        CMD_TRQ_TO_CUR  = 2'd0,
        CMD_CUR_TO_TRQ  = 2'd1,
        CMD_RPM_TO_ERPM = 2'd2,
        CMD_ERPM_TO_RPM = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_POLE_PAIRS = 2'd0;
    localparam logic [1:0] REG_FLUX       = 2'd1;
    localparam logic [1:0] REG_LD         = 2'd2;
    localparam logic [1:0] REG_LQ         = 2'd3;

    localparam int EFF_W  = 42;
    localparam int DEN_W  = 48;
    localparam int NUM_W  = 53;
    localparam int QUO_W  = 32;
    localparam int ROOT_W = 17;
    localparam int RAD_W  = 34;

    localparam logic signed [31:0] SPD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SPD_MIN = 32'sh80000000;

    typedef struct packed {
        cmd_t                    cmd;
        logic                    brake;
        logic                    sat;
        logic                    neg;
        logic [15:0]             aid;
        logic signed [15:0]      torque;
        logic signed [31:0]      speed;
        logic signed [25:0]      power;
        logic [NUM_W-1:0]        rem;
        logic [NUM_W-1:0]        den;
        logic [QUO_W-1:0]        quo;
    } div_stage_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic                    brake;
        logic                    sat;
        logic signed [15:0]      torque;
        logic signed [31:0]      speed;
        logic signed [25:0]      power;
        logic [RAD_W-1:0]        rad;
        logic [ROOT_W-1:0]       root;
    } sqrt_stage_t;

endpackage

// ===== hw/rtl/pmsm_torque_current_conversion.sv =====
// PMSM torque/current conversion: four fixed point commands on motor constants.
// Pipelined: effective flux, products, 32-stage restoring divider, 17-stage root.
// Depends on pmsm_tc_pkg.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+---------------------------------------
//   command   | start / busy            | command, torque_request .. dc_current
//   config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//   result    | done (one-cycle strobe) | stator_current .. saturated
//
// One item enters per cycle; each result passes through the 32 divider stages and
// the 17 square root stages in line.
// busy and cfg_ready stay low and high: the pipeline never stalls, and the
// receiver cannot hold results off. Reset clears the valid bits and loads the
// register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module pmsm_torque_current_conversion (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic signed [15:0] torque_request,
    input  logic signed [15:0] id_current,
    input  logic signed [15:0] iq_current,
    input  logic signed [31:0] speed_value,
    input  logic [9:0]         bus_voltage,
    input  logic signed [15:0] dc_current,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output logic               done,
    output logic [15:0]        stator_current,
    output logic               use_brake_command,
    output logic signed [15:0] torque_estimate,
    output logic signed [31:0] speed_result,
    output logic signed [25:0] power_watts,
    output logic               saturated
);

    import pmsm_tc_pkg::*;

    logic [5:0]  pole_pairs_reg;
    logic [23:0] flux_reg;
    logic [23:0] ld_reg;
    logic [23:0] lq_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_pairs_reg <= 6'd1;
            flux_reg       <= '0;
            ld_reg         <= '0;
            lq_reg         <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_POLE_PAIRS: pole_pairs_reg <= cfg_data[5:0];
                REG_FLUX:       flux_reg       <= cfg_data;
                REG_LD:         ld_reg         <= cfg_data;
                REG_LQ:         lq_reg         <= cfg_data;
            endcase
        end
    end

    // stage 1: capture
    logic               s1_vld_reg;
    cmd_t               s1_cmd_reg;
    logic signed [15:0] s1_trq_reg, s1_id_reg, s1_iq_reg, s1_idc_reg;
    logic signed [31:0] s1_spd_reg;
    logic [9:0]         s1_volt_reg;

    always_ff @(posedge clk)
    begin
        s1_cmd_reg  <= cmd_t'(command);
        s1_trq_reg  <= torque_request;
        s1_id_reg   <= id_current;
        s1_iq_reg   <= iq_current;
        s1_spd_reg  <= speed_value;
        s1_volt_reg <= bus_voltage;
        s1_idc_reg  <= dc_current;
    end

    // stage 2: effective flux
    logic signed [24:0]      dl;
    logic signed [40:0]      dl_id;
    logic signed [EFF_W-1:0] eff_next;

    always_comb
    begin
        dl       = $signed({1'b0, ld_reg}) - $signed({1'b0, lq_reg});
        dl_id    = dl * s1_id_reg;
        eff_next = $signed({6'b0, flux_reg, 12'b0}) + EFF_W'(dl_id);
    end

    logic                    s2_vld_reg;
    cmd_t                    s2_cmd_reg;
    logic signed [EFF_W-1:0] s2_eff_reg;
    logic signed [15:0]      s2_trq_reg, s2_id_reg, s2_iq_reg, s2_idc_reg;
    logic signed [31:0]      s2_spd_reg;
    logic [9:0]              s2_volt_reg;

    always_ff @(posedge clk)
    begin
        s2_cmd_reg  <= s1_cmd_reg;
        s2_eff_reg  <= eff_next;
        s2_trq_reg  <= s1_trq_reg;
        s2_id_reg   <= s1_id_reg;
        s2_iq_reg   <= s1_iq_reg;
        s2_spd_reg  <= s1_spd_reg;
        s2_volt_reg <= s1_volt_reg;
        s2_idc_reg  <= s1_idc_reg;
    end

    // stage 3: denominator, speed product, power, magnitudes
    logic [40:0]        e_abs;
    logic [7:0]         p3;
    logic [48:0]        den_full;
    logic signed [38:0] spd_pp;
    logic signed [26:0] pwr;
    logic signed [31:0] s3_speed_next;
    logic               s3_sat_next;

    always_comb
    begin
        e_abs    = s2_eff_reg[EFF_W-1] ? 41'(-s2_eff_reg) : 41'(s2_eff_reg);
        p3       = {1'b0, pole_pairs_reg, 1'b0} + {2'b0, pole_pairs_reg};
        den_full = p3 * e_abs;
        spd_pp   = s2_spd_reg * $signed({1'b0, pole_pairs_reg});
        pwr      = $signed({1'b0, s2_volt_reg}) * s2_idc_reg;
        s3_speed_next = '0;
        s3_sat_next   = 1'b0;
        if (s2_cmd_reg == CMD_RPM_TO_ERPM)
        begin
            if (spd_pp > 39'(SPD_MAX))
            begin
                s3_speed_next = SPD_MAX;
                s3_sat_next   = 1'b1;
            end
            else if (spd_pp < 39'(SPD_MIN))
            begin
                s3_speed_next = SPD_MIN;
                s3_sat_next   = 1'b1;
            end
            else
            begin
                s3_speed_next = 32'(spd_pp);
            end
        end
    end

    logic               s3_vld_reg;
    cmd_t               s3_cmd_reg;
    logic [DEN_W-1:0]   s3_den_reg;
    logic               s3_e_neg_reg, s3_iq_neg_reg, s3_spd_neg_reg, s3_brake_reg, s3_sat_reg;
    logic [15:0]        s3_trq_mag_reg, s3_aid_reg, s3_iq_mag_reg;
    logic [31:0]        s3_spd_mag_reg;
    logic signed [31:0] s3_speed_reg;
    logic signed [25:0] s3_power_reg;

    always_ff @(posedge clk)
    begin
        s3_cmd_reg     <= s2_cmd_reg;
        s3_den_reg     <= den_full[DEN_W-1:0];
        s3_e_neg_reg   <= s2_eff_reg[EFF_W-1];
        s3_iq_neg_reg  <= s2_iq_reg[15];
        s3_spd_neg_reg <= s2_spd_reg[31];
        s3_brake_reg   <= (s2_cmd_reg == CMD_TRQ_TO_CUR) && s2_trq_reg[15];
        s3_trq_mag_reg <= s2_trq_reg[15] ? 16'(-s2_trq_reg) : 16'(s2_trq_reg);
        s3_aid_reg     <= s2_id_reg[15] ? 16'(-s2_id_reg) : 16'(s2_id_reg);
        s3_iq_mag_reg  <= s2_iq_reg[15] ? 16'(-s2_iq_reg) : 16'(s2_iq_reg);
        s3_spd_mag_reg <= s2_spd_reg[31] ? 32'(-s2_spd_reg) : 32'(s2_spd_reg);
        s3_speed_reg   <= s3_speed_next;
        s3_sat_reg     <= s3_sat_next;
        s3_power_reg   <= (s2_cmd_reg == CMD_ERPM_TO_RPM) ? 26'(pwr) : '0;
    end

    // stage 4: torque product, divider setup
    logic [63:0]        prod;
    logic [NUM_W-1:0]   num, dvs;
    logic               s4_sat_next;
    logic signed [31:0] s4_speed_next;

    always_comb
    begin
        prod          = s3_den_reg * s3_iq_mag_reg;
        num           = '0;
        dvs           = '0;
        s4_sat_next   = s3_sat_reg;
        s4_speed_next = s3_speed_reg;
        unique case (s3_cmd_reg)
            CMD_TRQ_TO_CUR:
            begin
                num = {s3_trq_mag_reg, 37'b0};
                dvs = NUM_W'(s3_den_reg);
                if (s3_den_reg == '0 || (num >> 16) >= dvs)
                begin
                    s4_sat_next = 1'b1;
                end
            end
            CMD_ERPM_TO_RPM:
            begin
                num = NUM_W'(s3_spd_mag_reg);
                dvs = NUM_W'(pole_pairs_reg);
                if (pole_pairs_reg == '0)
                begin
                    s4_sat_next = 1'b1;
                    if (s3_spd_mag_reg == '0)
                        s4_speed_next = '0;
                    else if (s3_spd_neg_reg)
                        s4_speed_next = SPD_MIN;
                    else
                        s4_speed_next = SPD_MAX;
                end
            end
            CMD_CUR_TO_TRQ, CMD_RPM_TO_ERPM:
            begin
                num = '0;
            end
        endcase
    end

    logic               s4_vld_reg;
    cmd_t               s4_cmd_reg;
    logic [63:0]        s4_prod_reg;
    logic               s4_tneg_reg, s4_spd_neg_reg, s4_brake_reg, s4_sat_reg;
    logic [NUM_W-1:0]   s4_rem_reg, s4_den_reg;
    logic [15:0]        s4_aid_reg;
    logic signed [31:0] s4_speed_reg;
    logic signed [25:0] s4_power_reg;

    always_ff @(posedge clk)
    begin
        s4_cmd_reg     <= s3_cmd_reg;
        s4_prod_reg    <= prod;
        s4_tneg_reg    <= s3_e_neg_reg ^ s3_iq_neg_reg;
        s4_spd_neg_reg <= s3_spd_neg_reg;
        s4_brake_reg   <= s3_brake_reg;
        s4_sat_reg     <= s4_sat_next;
        s4_rem_reg     <= num;
        s4_den_reg     <= dvs;
        s4_aid_reg     <= s3_aid_reg;
        s4_speed_reg   <= s4_speed_next;
        s4_power_reg   <= s3_power_reg;
    end

    // stage 5: torque rounding and clamp, divider entry
    logic [63:0] rsum;
    logic [26:0] rnd;
    div_stage_t  div_entry;

    always_comb
    begin
        rsum      = s4_prod_reg + (64'd1 << 36);
        rnd       = rsum[63:37];
        div_entry = '{cmd: s4_cmd_reg, brake: s4_brake_reg, sat: s4_sat_reg,
                      neg: s4_spd_neg_reg, aid: s4_aid_reg, torque: '0,
                      speed: s4_speed_reg, power: s4_power_reg, rem: s4_rem_reg,
                      den: s4_den_reg, quo: '0};
        if (s4_cmd_reg == CMD_CUR_TO_TRQ)
        begin
            if (s4_tneg_reg && rnd != '0)
            begin
                if (rnd > 27'd32768)
                begin
                    div_entry.torque = 16'sh8000;
                    div_entry.sat    = 1'b1;
                end
                else
                begin
                    div_entry.torque = 16'(-$signed({1'b0, rnd}));
                end
            end
            else
            begin
                if (rnd > 27'd32767)
                begin
                    div_entry.torque = 16'sh7FFF;
                    div_entry.sat    = 1'b1;
                end
                else
                begin
                    div_entry.torque = 16'(rnd);
                end
            end
        end
    end

    div_stage_t  div_reg [0:QUO_W];
    logic [QUO_W:0] div_vld_reg;

    always_ff @(posedge clk)
    begin
        div_reg[0] <= div_entry;
    end

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        localparam int K = QUO_W - 1 - j;
        div_stage_t stage_next;

        always_comb
        begin
            stage_next = div_reg[j];
            if ((div_reg[j].rem >> K) >= div_reg[j].den)
            begin
                stage_next.rem    = div_reg[j].rem - (div_reg[j].den << K);
                stage_next.quo[K] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[j+1] <= stage_next;
        end
    end

    // squares and rpm sign
    div_stage_t         dq;
    logic signed [31:0] p_speed_next;

    always_comb
    begin
        dq           = div_reg[QUO_W];
        p_speed_next = dq.speed;
        if (dq.cmd == CMD_ERPM_TO_RPM && !dq.sat)
            p_speed_next = dq.neg ? 32'(-dq.quo) : 32'(dq.quo);
    end

    logic               p_vld_reg;
    cmd_t               p_cmd_reg;
    logic               p_brake_reg, p_sat_reg;
    logic signed [15:0] p_torque_reg;
    logic signed [31:0] p_speed_reg;
    logic signed [25:0] p_power_reg;
    logic [31:0]        p_sa_reg, p_sq_reg;

    always_ff @(posedge clk)
    begin
        p_cmd_reg    <= dq.cmd;
        p_brake_reg  <= dq.brake;
        p_sat_reg    <= dq.sat;
        p_torque_reg <= dq.torque;
        p_speed_reg  <= p_speed_next;
        p_power_reg  <= dq.power;
        p_sa_reg     <= dq.aid * dq.aid;
        p_sq_reg     <= dq.quo[15:0] * dq.quo[15:0];
    end

    sqrt_stage_t      sq_reg [0:ROOT_W];
    logic [ROOT_W:0]  sq_vld_reg;

    always_ff @(posedge clk)
    begin
        sq_reg[0] <= '{cmd: p_cmd_reg, brake: p_brake_reg, sat: p_sat_reg,
                       torque: p_torque_reg, speed: p_speed_reg, power: p_power_reg,
                       rad: RAD_W'(p_sa_reg) + RAD_W'(p_sq_reg), root: '0};
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        localparam int K = ROOT_W - 1 - j;
        sqrt_stage_t     stage_next;
        logic [RAD_W:0]  trial;

        always_comb
        begin
            stage_next = sq_reg[j];
            trial      = ((RAD_W+1)'(sq_reg[j].root) << (K + 1))
                       + ((RAD_W+1)'(1) << (2 * K));
            if ({1'b0, sq_reg[j].rad} >= trial)
            begin
                stage_next.rad     = sq_reg[j].rad - trial[RAD_W-1:0];
                stage_next.root[K] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[j+1] <= stage_next;
        end
    end

    // output stage
    sqrt_stage_t sf;
    logic [15:0] stator_next;
    logic        sat_next;

    always_comb
    begin
        sf          = sq_reg[ROOT_W];
        stator_next = '0;
        sat_next    = sf.sat;
        if (sf.cmd == CMD_TRQ_TO_CUR)
        begin
            if (sf.sat || sf.root[ROOT_W-1])
            begin
                stator_next = 16'hFFFF;
                sat_next    = 1'b1;
            end
            else
            begin
                stator_next = sf.root[15:0];
            end
        end
    end

    logic               out_vld_reg;
    logic [15:0]        stator_reg;
    logic               brake_reg, sat_reg;
    logic signed [15:0] torque_reg;
    logic signed [31:0] speed_reg;
    logic signed [25:0] power_reg;

    always_ff @(posedge clk)
    begin
        stator_reg <= stator_next;
        brake_reg  <= sf.brake;
        sat_reg    <= sat_next;
        torque_reg <= sf.torque;
        speed_reg  <= sf.speed;
        power_reg  <= sf.power;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            div_vld_reg <= '0;
            p_vld_reg   <= 1'b0;
            sq_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= start && !busy;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            div_vld_reg <= {div_vld_reg[QUO_W-1:0], s4_vld_reg};
            p_vld_reg   <= div_vld_reg[QUO_W];
            sq_vld_reg  <= {sq_vld_reg[ROOT_W-1:0], p_vld_reg};
            out_vld_reg <= sq_vld_reg[ROOT_W];
        end
    end

    assign done              = out_vld_reg;
    assign stator_current    = stator_reg;
    assign use_brake_command = brake_reg;
    assign torque_estimate   = torque_reg;
    assign speed_result      = speed_reg;
    assign power_watts       = power_reg;
    assign saturated         = sat_reg;

endmodule

// ===== test/pmsm_torque_current_conversion_tb.sv =====
// Self-checking testbench for pmsm_torque_current_conversion: directed table, then random
// commands under several motor constant settings, checked against an in-bench predictor.
// Depends on pmsm_tc_pkg and the block RTL.
`timescale 1ns / 1ps

module pmsm_torque_current_conversion_tb;

    import pmsm_tc_pkg::*;

    typedef struct {
        logic [15:0]        stator;
        logic               brake;
        logic signed [15:0] torque;
        logic signed [31:0] speed;
        logic signed [25:0] power;
        logic               sat;
    } conv_result_t;

    typedef struct {
        cmd_t               cmd;
        logic signed [15:0] trq;
        logic signed [15:0] id;
        logic signed [15:0] iq;
        logic signed [31:0] spd;
        logic [9:0]         volt;
        logic signed [15:0] idc;
    } conv_item_t;

    typedef struct {
        conv_item_t   item;
        bit           typed;
        conv_result_t res;
    } table_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         command;
    logic signed [15:0] torque_request;
    logic signed [15:0] id_current;
    logic signed [15:0] iq_current;
    logic signed [31:0] speed_value;
    logic [9:0]         bus_voltage;
    logic signed [15:0] dc_current;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               done;
    logic [15:0]        stator_current;
    logic               use_brake_command;
    logic signed [15:0] torque_estimate;
    logic signed [31:0] speed_result;
    logic signed [25:0] power_watts;
    logic               saturated;

    longint       pole_pairs;
    longint       flux;
    longint       ld;
    longint       lq;
    conv_result_t pending[$];
    int           errors;

    pmsm_torque_current_conversion u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .command           (command),
        .torque_request    (torque_request),
        .id_current        (id_current),
        .iq_current        (iq_current),
        .speed_value       (speed_value),
        .bus_voltage       (bus_voltage),
        .dc_current        (dc_current),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .done              (done),
        .stator_current    (stator_current),
        .use_brake_command (use_brake_command),
        .torque_estimate   (torque_estimate),
        .speed_result      (speed_result),
        .power_watts       (power_watts),
        .saturated         (saturated)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #5ms;
        $display("pmsm_torque_current_conversion_tb: errors");
        $finish;
    end

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic conv_result_t convert(conv_item_t it);
        conv_result_t  r;
        longint        flux_eff;
        longint        spd;
        longint unsigned den;
        longint unsigned quo;
        longint unsigned prod;
        longint unsigned rnd;
        longint        speed;
        r        = '{default: '0};
        flux_eff = flux * 4096 + (ld - lq) * longint'(it.id);
        spd      = longint'(it.spd);
        case (it.cmd)
            CMD_TRQ_TO_CUR:
            begin
                den     = 3 * pole_pairs * magnitude(flux_eff);
                r.brake = it.trq < 0;
                if (den == 0)
                begin
                    r.stator = 16'hFFFF;
                    r.sat    = 1'b1;
                end
                else
                begin
                    quo = (magnitude(longint'(it.trq)) << 37) / den;
                    if (quo > 65535)
                    begin
                        r.stator = 16'hFFFF;
                        r.sat    = 1'b1;
                    end
                    else
                    begin
                        prod = floor_sqrt(magnitude(longint'(it.id)) ** 2 + quo * quo);
                        if (prod > 65535)
                        begin
                            prod  = 65535;
                            r.sat = 1'b1;
                        end
                        r.stator = prod[15:0];
                    end
                end
            end
            CMD_CUR_TO_TRQ:
            begin
                prod = 3 * pole_pairs * magnitude(flux_eff) * magnitude(longint'(it.iq));
                rnd  = (prod + (64'd1 << 36)) >> 37;
                if (((flux_eff < 0) != (it.iq < 0)) && rnd != 0)
                begin
                    if (rnd > 32768)
                    begin
                        rnd   = 32768;
                        r.sat = 1'b1;
                    end
                    r.torque = 16'(-longint'(rnd));
                end
                else
                begin
                    if (rnd > 32767)
                    begin
                        rnd   = 32767;
                        r.sat = 1'b1;
                    end
                    r.torque = 16'(rnd);
                end
            end
            CMD_RPM_TO_ERPM:
            begin
                speed = spd * pole_pairs;
                if (speed > 64'sd2147483647)
                begin
                    speed = 64'sd2147483647;
                    r.sat = 1'b1;
                end
                if (speed < -64'sd2147483648)
                begin
                    speed = -64'sd2147483648;
                    r.sat = 1'b1;
                end
                r.speed = 32'(speed);
            end
            default:
            begin
                if (pole_pairs == 0)
                begin
                    r.sat   = 1'b1;
                    r.speed = (spd > 0) ? SPD_MAX : (spd < 0) ? SPD_MIN : 32'sd0;
                end
                else
                begin
                    speed   = magnitude(spd) / pole_pairs;
                    r.speed = 32'((spd < 0) ? -speed : speed);
                end
                r.power = 26'(longint'(it.volt) * longint'(it.idc));
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        conv_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending.size() == 0)
            begin
                $error("result with nothing pending");
                errors++;
            end
            else
            begin
                exp_res = pending.pop_front();
                if (stator_current !== exp_res.stator)
                begin
                    $error("stator_current exp %0d got %0d", exp_res.stator, stator_current);
                    errors++;
                end
                if (use_brake_command !== exp_res.brake)
                begin
                    $error("use_brake_command exp %0d got %0d", exp_res.brake,
                           use_brake_command);
                    errors++;
                end
                if (torque_estimate !== exp_res.torque)
                begin
                    $error("torque_estimate exp %0d got %0d", exp_res.torque, torque_estimate);
                    errors++;
                end
                if (speed_result !== exp_res.speed)
                begin
                    $error("speed_result exp %0d got %0d", exp_res.speed, speed_result);
                    errors++;
                end
                if (power_watts !== exp_res.power)
                begin
                    $error("power_watts exp %0d got %0d", exp_res.power, power_watts);
                    errors++;
                end
                if (saturated !== exp_res.sat)
                begin
                    $error("saturated exp %0d got %0d", exp_res.sat, saturated);
                    errors++;
                end
            end
        end
    end

    // hold cfg_valid high across back-to-back writes; the caller drops it
    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_POLE_PAIRS: pole_pairs = value[5:0];
            REG_FLUX:       flux = value;
            REG_LD:         ld = value;
            default:        lq = value;
        endcase
    endtask

    task automatic load_constants(int pp, int fl, int dind, int qind);
        write_reg(REG_POLE_PAIRS, 24'(pp));
        write_reg(REG_FLUX, 24'(fl));
        write_reg(REG_LD, 24'(dind));
        write_reg(REG_LQ, 24'(qind));
        cfg_valid <= 1'b0;
    endtask

    // when a gap is drawn, hold start low after the transfer and wait the gap out
    task automatic send(conv_item_t it, bit typed, conv_result_t typed_res, bit gaps);
        int gap;
        start          <= 1'b1;
        command        <= it.cmd;
        torque_request <= it.trq;
        id_current     <= it.id;
        iq_current     <= it.iq;
        speed_value    <= it.spd;
        bus_voltage    <= it.volt;
        dc_current     <= it.idc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending.push_back(typed ? typed_res : convert(it));
        gap = 0;
        if (gaps && $urandom_range(0, 2) == 0)
            gap = $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 64) - 32);
            3:       return 16'($urandom_range(0, 2000) - 1000);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic conv_item_t random_item();
        conv_item_t it;
        it.cmd  = cmd_t'($urandom_range(0, 3));
        it.trq  = pick16();
        it.id   = pick16();
        it.iq   = pick16();
        it.idc  = pick16();
        it.volt = 10'($urandom());
        case ($urandom_range(0, 4))
            0:       it.spd = 32'($urandom_range(0, 20000) - 10000);
            1:       it.spd = ($urandom_range(0, 1) != 0) ? SPD_MAX : SPD_MIN;
            default: it.spd = 32'($urandom());
        endcase
        return it;
    endfunction

    table_row_t   directed[$];
    conv_result_t none;

    initial
    begin
        int settings[8][4];
        errors         = 0;
        pole_pairs     = 1;
        flux           = 0;
        ld             = 0;
        lq             = 0;
        none           = '{default: '0};
        rst_n          = 1'b0;
        start          = 1'b0;
        command        = CMD_TRQ_TO_CUR;
        torque_request = '0;
        id_current     = '0;
        iq_current     = '0;
        speed_value    = '0;
        bus_voltage    = '0;
        dc_current     = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_POLE_PAIRS;
        cfg_data       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back('{'{CMD_TRQ_TO_CUR, 16'sd100, 16'sd0, 16'sd0, 32'sd0, 10'd0, 16'sd0},
                             1, '{16'hFFFF, 1'b0, 16'sd0, 32'sd0, 26'sd0, 1'b1}});
        directed.push_back('{'{CMD_TRQ_TO_CUR, -16'sd32768, 16'sd0, 16'sd0, 32'sd0, 10'd0,
                               16'sd0}, 1, '{16'hFFFF, 1'b1, 16'sd0, 32'sd0, 26'sd0, 1'b1}});
        directed.push_back('{'{CMD_CUR_TO_TRQ, 16'sd0, -16'sd32768, 16'sd32767, 32'sd0, 10'd0,
                               16'sd0}, 1, none});
        directed.push_back('{'{CMD_RPM_TO_ERPM, 16'sd0, 16'sd0, 16'sd0, SPD_MAX, 10'd0,
                               16'sd0}, 1, '{16'd0, 1'b0, 16'sd0, SPD_MAX, 26'sd0, 1'b0}});
        directed.push_back('{'{CMD_ERPM_TO_RPM, 16'sd0, 16'sd0, 16'sd0, SPD_MIN, 10'd1023,
                               -16'sd32768}, 1,
                             '{16'd0, 1'b0, 16'sd0, SPD_MIN, -26'sd33521664, 1'b0}});
        directed.push_back('{'{CMD_ERPM_TO_RPM, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 10'd1023,
                               16'sd32767}, 0, none});
        foreach (directed[i])
            send(directed[i].item, directed[i].typed, directed[i].res, 0);
        drain();

        load_constants(32, 24'hFFFFFF, 24'hFFFFFF, 0);
        directed.delete();
        directed.push_back('{'{CMD_TRQ_TO_CUR, 16'sd32767, 16'sd32767, 16'sd0, 32'sd0, 10'd0,
                               16'sd0}, 0, none});
        directed.push_back('{'{CMD_TRQ_TO_CUR, -16'sd32768, -16'sd32768, 16'sd0, 32'sd0, 10'd0,
                               16'sd0}, 0, none});
        directed.push_back('{'{CMD_TRQ_TO_CUR, 16'sd1, 16'sd5, 16'sd0, 32'sd0, 10'd0, 16'sd0},
                             0, none});
        directed.push_back('{'{CMD_CUR_TO_TRQ, 16'sd0, 16'sd32767, 16'sd32767, 32'sd0, 10'd0,
                               16'sd0}, 0, none});
        directed.push_back('{'{CMD_CUR_TO_TRQ, 16'sd0, -16'sd32768, 16'sd1, 32'sd0, 10'd0,
                               16'sd0}, 0, none});
        directed.push_back('{'{CMD_RPM_TO_ERPM, 16'sd0, 16'sd0, 16'sd0, SPD_MIN, 10'd0,
                               16'sd0}, 0, none});
        directed.push_back('{'{CMD_ERPM_TO_RPM, 16'sd0, 16'sd0, 16'sd0, -32'sd1000, 10'd512,
                               16'sd16}, 0, none});
        foreach (directed[i])
            send(directed[i].item, 0, none, 0);
        drain();

        load_constants(0, 24'h123456, 24'h000100, 24'h000200);
        directed.delete();
        for (int c = 0; c < 4; c++)
            send('{cmd_t'(c), -16'sd5, 16'sd3, 16'sd7, (c == 3) ? 32'sd0 : 32'sd77, 10'd9,
                   16'sd2}, 0, none, 0);
        drain();

        settings = '{'{1, 0, 0, 0}, '{0, 24'h800000, 24'h000FFF, 24'h001000},
                     '{32, 24'hFFFFFF, 24'hFFFFFF, 0}, '{63, 24'hFFFFFF, 0, 24'hFFFFFF},
                     '{4, 24'h100000, 24'h004000, 24'h008000}, '{7, 24'h000400, 0, 0},
                     '{2, 24'h3A0000, 24'h00C000, 24'h003000}, '{0, 0, 0, 0}};
        foreach (settings[s])
        begin
            if (s == 7)
                load_constants($urandom_range(1, 32), $urandom(), $urandom(), $urandom());
            else
                load_constants(settings[s][0], settings[s][1], settings[s][2], settings[s][3]);
            repeat (225)
                send(random_item(), 0, none, 1);
            drain();
        end

        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("pmsm_torque_current_conversion_tb: clean");
        else
            $display("pmsm_torque_current_conversion_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pmsm_tc_pkg.sv
hw/rtl/pmsm_torque_current_conversion.sv
test/pmsm_torque_current_conversion_tb.sv
